[rtl/core/bms_pkg.sv]
package bms_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int THRESH_W    = 4;
    localparam int WIN_CELLS   = 9;
    localparam int COUNT_W     = 4;

    localparam int MIN_SIDE      = 10;
    localparam int SIDE_RESET    = 52;
    localparam int THRESH_RESET  = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_MAP_SIDE       = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_WALL_THRESHOLD = 1'b1;

    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // one request as it leaves the front stage
    typedef struct packed {
        logic is_cell;
        logic wall_bit;
        logic emit;
        logic force_wall;
        logic last;
    } item_ctl_t;

    function automatic logic [COUNT_W-1:0] count_walls(input logic [WIN_CELLS-1:0] win);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WIN_CELLS; i++)
        begin
            n = n + COUNT_W'(win[i]);
        end
        return n;
    endfunction

endpackage

[rtl/core/bms_ram.sv]
module bms_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/bms_front.sv]
module bms_front #(
    parameter int MAX_SIDE = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           accept,
    input  logic                           kind,
    input  logic                           cell_wall,
    input  logic                           advance,
    output logic                           s1_valid,
    output bms_pkg::item_ctl_t             s1_ctl,
    output logic [$clog2(MAX_SIDE)-1:0]    s1_col,
    output logic [$clog2(MAX_SIDE)-1:0]    rd_addr
);

    import bms_pkg::*;

    localparam int AW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int SIDE_INIT = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

    function automatic logic [SW-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v);
        if (int'(v) < MIN_SIDE)
        begin
            return SW'(MIN_SIDE);
        end
        else if (int'(v) > MAX_SIDE)
        begin
            return SW'(MAX_SIDE);
        end
        return SW'(v);
    endfunction

    logic [SW-1:0] side_reg;
    logic [AW-1:0] in_col_reg, in_col_next;
    logic [AW-1:0] in_row_reg, in_row_next;
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [AW-1:0] out_row_reg, out_row_next;
    logic          s1_valid_reg;
    item_ctl_t     s1_ctl_reg, ctl_next;
    logic [AW-1:0] s1_col_reg;

    logic [AW-1:0] last_idx;
    logic          at_origin;
    logic          is_cell;
    logic [AW-1:0] base_row, base_col;
    logic          border;
    logic          side_write;

    assign side_write = cfg_write && (cfg_index == REG_MAP_SIDE);
    assign last_idx   = AW'(side_reg - SW'(1));
    assign at_origin  = (in_col_reg == '0) && (in_row_reg == '0);
    assign is_cell    = (kind == KIND_CELL);

    always_comb
    begin
        // a new map restarts the output position
        base_row = (is_cell && at_origin) ? '0 : out_row_reg;
        base_col = (is_cell && at_origin) ? '0 : out_col_reg;

        ctl_next.is_cell  = is_cell;
        ctl_next.wall_bit = cell_wall;
        if (is_cell)
        begin
            ctl_next.emit = (in_row_reg > AW'(1))
                || ((in_row_reg == AW'(1)) && (in_col_reg != '0));
        end
        else
        begin
            ctl_next.emit = at_origin && !((out_row_reg == '0) && (out_col_reg == '0));
        end
        border = (base_row == '0) || (base_col == '0)
            || (base_row == last_idx) || (base_col == last_idx);
        ctl_next.force_wall = !is_cell || border;
        ctl_next.last       = (base_row == last_idx) && (base_col == last_idx);

        out_row_next = base_row;
        out_col_next = base_col;
        if (ctl_next.emit)
        begin
            if (ctl_next.last)
            begin
                out_row_next = '0;
                out_col_next = '0;
            end
            else if (base_col == last_idx)
            begin
                out_col_next = '0;
                out_row_next = base_row + AW'(1);
            end
            else
            begin
                out_col_next = base_col + AW'(1);
            end
        end

        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (is_cell)
        begin
            if (in_col_reg == last_idx)
            begin
                in_col_next = '0;
                in_row_next = (in_row_reg == last_idx) ? '0 : in_row_reg + AW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg    <= SW'(SIDE_INIT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (side_write)
        begin
            side_reg    <= clamp_side(cfg_data);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (accept)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_ctl_reg   <= ctl_next;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= in_col_reg;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign s1_col   = s1_col_reg;
    assign rd_addr  = in_col_reg;

endmodule

[rtl/core/bms_window.sv]
module bms_window (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [bms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s1_valid,
    input  bms_pkg::item_ctl_t              s1_ctl,
    input  logic [1:0]                      rows_rd,
    output logic                            advance,
    output logic                            rows_wr_en,
    output logic [1:0]                      rows_wr,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic                            out_wall,
    output logic                            out_last
);

    import bms_pkg::*;

    logic [THRESH_W-1:0]  thresh_reg;
    logic [WIN_CELLS-1:0] window_reg, window_next;
    logic                 out_valid_reg;
    logic                 out_wall_reg, out_last_reg;
    logic                 take;
    logic                 wall;

    assign advance = !out_valid_reg || !out_stall;
    assign take    = s1_valid && advance;

    // column shifted in: bit0 two rows up, bit1 one row up, bit2 current cell
    assign window_next = {window_reg[WIN_CELLS-4:0], s1_ctl.wall_bit, rows_rd[1], rows_rd[0]};
    assign wall        = (count_walls(window_next) >= COUNT_W'(thresh_reg));

    // upper row takes the old lower row, lower row takes the new cell
    assign rows_wr_en = take && s1_ctl.is_cell;
    assign rows_wr    = {s1_ctl.wall_bit, rows_rd[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESH_W'(THRESH_RESET);
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_WALL_THRESHOLD))
            begin
                thresh_reg <= cfg_data[THRESH_W-1:0];
            end

            if (cfg_write && (cfg_index == REG_MAP_SIDE))
            begin
                window_reg <= '0;
            end
            else if (take && s1_ctl.is_cell)
            begin
                window_reg <= window_next;
            end

            if (take)
            begin
                out_valid_reg <= s1_ctl.emit;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_wall_reg <= s1_ctl.force_wall || wall;
            out_last_reg <= s1_ctl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_wall  = out_wall_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/core/binary_majority_smoothing_3x3.sv]
// channel   direction   handshake              payload
// in        request in  in_valid / in_stall    kind, cell_wall
// out       result out  out_valid / out_stall  out_wall, out_last
// cfg       write only  cfg_write              cfg_index, cfg_data
//
// one request per clock while not in_stall; results reach out via the first stage
// the line-store ram reads when a request is taken and writes, on its own port, when
// a cell request leaves the first stage
// rst_n clears counters, window and valids; line stores hold garbage until written
// out_stall holds the output register; in_stall rises only while a result waits there
// and a second request sits behind it
module binary_majority_smoothing_3x3 #(
    parameter int MAX_SIDE = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [bms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic                            cell_wall,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            out_wall,
    output logic                            out_last
);

    import bms_pkg::*;

    localparam int AW = $clog2(MAX_SIDE);

    logic          accept;
    logic          advance;
    logic          s1_valid;
    item_ctl_t     s1_ctl;
    logic [AW-1:0] s1_col;
    logic [AW-1:0] rd_addr;
    logic [1:0]    rows_rd;
    logic [1:0]    rows_wr;
    logic          rows_wr_en;

    assign in_stall = s1_valid && !advance;
    assign accept   = in_valid && !in_stall;

    bms_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .kind      (kind),
        .cell_wall (cell_wall),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .s1_col    (s1_col),
        .rd_addr   (rd_addr)
    );

    // both line stores share one word: bit0 upper row, bit1 lower row
    bms_ram #(
        .WIDTH (2),
        .DEPTH (MAX_SIDE)
    ) u_rows (
        .clk     (clk),
        .wr_en   (rows_wr_en),
        .wr_addr (s1_col),
        .wr_data (rows_wr),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rows_rd)
    );

    bms_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s1_valid   (s1_valid),
        .s1_ctl     (s1_ctl),
        .rows_rd    (rows_rd),
        .advance    (advance),
        .rows_wr_en (rows_wr_en),
        .rows_wr    (rows_wr),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_wall   (out_wall),
        .out_last   (out_last)
    );

endmodule

[rtl/core/bms_checker.sv]
module bms_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic out_wall,
    input logic out_last
);

    // the last cell of a map is a corner, hence always wall
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_wall)
        else $error("last cell not wall");

    // input backs up only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // a fresh result comes from a request that passed through the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without request");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_wall) && $stable(out_last))
        else $error("held result changed");

endmodule

bind binary_majority_smoothing_3x3 bms_checker u_checker (.*);

[test/binary_majority_smoothing_3x3_tb.sv]
`timescale 1ns / 100ps

module binary_majority_smoothing_3x3_tb;

    import bms_pkg::*;

    localparam int SIDE_LIMIT    = 128;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int ITEM_TARGET   = 1500;
    localparam int SHOWN_ERRORS  = 10;

    typedef struct packed {
        logic wall;
        logic last;
    } smoothed_cell_t;

    class smoothing_scoreboard;
        bit                    upper_row [SIDE_LIMIT];
        bit                    lower_row [SIDE_LIMIT];
        bit [8:0]              window;
        int unsigned           in_row;
        int unsigned           in_col;
        int unsigned           out_index;
        logic [CFG_DATA_W-1:0] side_reg;
        logic [THRESH_W-1:0]   thresh_reg;
        smoothed_cell_t        pending [$];
        int unsigned           errors;

        function new();
            side_reg   = CFG_DATA_W'(SIDE_RESET);
            thresh_reg = THRESH_W'(THRESH_RESET);
            errors     = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            window    = '0;
            in_row    = 0;
            in_col    = 0;
            out_index = 0;
        endfunction

        function int unsigned side_now();
            int unsigned s;
            s = 32'(side_reg);
            if (s < MIN_SIDE)
                s = MIN_SIDE;
            if (s > SIDE_LIMIT)
                s = SIDE_LIMIT;
            return s;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MAP_SIDE)
            begin
                side_reg = data;
                clear_stream();
            end
            else if (idx == REG_WALL_THRESHOLD)
            begin
                thresh_reg = data[THRESH_W-1:0];
            end
        endfunction

        // border cells come out as wall whatever the window holds
        function void emit_cell(int unsigned s, bit interior_wall);
            int unsigned    r;
            int unsigned    c;
            smoothed_cell_t exp_cell;
            r = out_index / s;
            c = out_index % s;
            exp_cell.last = (out_index == s * s - 1);
            exp_cell.wall = (r == 0 || c == 0 || r == s - 1 || c == s - 1) ? 1'b1 : interior_wall;
            out_index = exp_cell.last ? 0 : out_index + 1;
            pending.insert(pending.size(), exp_cell);
        endfunction

        function void note_request(logic k, logic c);
            int unsigned s;
            int unsigned pos;
            s = side_now();
            if (in_col >= s)
                in_col = 0;
            if (in_row >= s)
                in_row = 0;
            if (k == KIND_DRAIN)
            begin
                // drains only count once the whole map has been taken
                if (in_col == 0 && in_row == 0 && out_index != 0)
                    emit_cell(s, 1'b1);
                return;
            end
            if (in_col == 0 && in_row == 0)
                out_index = 0;
            window = {window[5:0], c, lower_row[in_col], upper_row[in_col]};
            upper_row[in_col] = lower_row[in_col];
            lower_row[in_col] = c;
            pos = in_row * s + in_col;
            if (pos >= s + 1)
                emit_cell(s, $countones(window) >= thresh_reg);
            in_col++;
            if (in_col >= s)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= s)
                    in_row = 0;
            end
        endfunction

        function void check_result(logic w, logic l);
            smoothed_cell_t exp_cell;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("%0t: unexpected result wall %b last %b", $time, w, l);
                return;
            end
            exp_cell = pending.pop_front();
            if (w !== exp_cell.wall || l !== exp_cell.last)
            begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("%0t: mismatch expected wall %b last %b, got wall %b last %b",
                             $time, exp_cell.wall, exp_cell.last, w, l);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   kind;
    logic                   cell_wall;
    logic                   out_valid;
    logic                   out_stall;
    logic                   out_wall;
    logic                   out_last;

    smoothing_scoreboard sb;
    bit                  calm;
    int unsigned         cells_sent;
    int unsigned         idle_cycles;

    binary_majority_smoothing_3x3 #(
        .MAX_SIDE(SIDE_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .cell_wall (cell_wall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_wall  (out_wall),
        .out_last  (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_run();
        if (calm)
            return $urandom_range(20, 60);
        if ($urandom_range(0, 99) < 60)
            return $urandom_range(1, 4);
        return $urandom_range(5, 30);
    endfunction

    function automatic int unsigned pick_drains(int unsigned s);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return s + 1;
        if (r < 87)
            return s + 1 + $urandom_range(1, 3);
        return $urandom_range(0, s);
    endfunction

    task automatic send_request(input logic k, input logic c);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        cell_wall <= c;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_request(k, c);
        cells_sent++;
    endtask

    task automatic hold_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    // drains and early cells give no result, so let the pipe empty as well
    task automatic wait_idle();
        hold_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic configure(input bit do_side, input logic [CFG_DATA_W-1:0] side_val,
                             input bit do_thr, input logic [THRESH_W-1:0] thr);
        logic [CFG_DATA_W-1:0] data;
        wait_idle();
        if (do_side)
            write_reg(REG_MAP_SIDE, side_val);
        if (do_thr)
        begin
            // upper bits are junk on purpose
            data = CFG_DATA_W'($urandom_range(0, 255));
            data[THRESH_W-1:0] = thr;
            write_reg(REG_WALL_THRESHOLD, data);
        end
    endtask

    task automatic run_map(input int unsigned cells, input int unsigned drains,
                           input int unsigned fill_pct, input bit force_hold);
        int unsigned hold_at;
        hold_at = (force_hold || $urandom_range(0, 3) == 0) ? $urandom_range(0, cells - 1) : cells;
        for (int unsigned i = 0; i < cells; i++)
        begin
            // stray drains in mid-map are dropped by the block
            if ($urandom_range(0, 99) < 3)
                send_request(KIND_DRAIN, 1'($urandom_range(0, 1)));
            send_request(KIND_CELL, $urandom_range(0, 99) < fill_pct);
            if (i == hold_at)
                hold_for_results();
        end
        for (int unsigned i = 0; i < drains; i++)
            send_request(KIND_DRAIN, 1'($urandom_range(0, 1)));
    endtask

    // result side
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(out_wall, out_last);
    end

    initial
    begin
        int unsigned stall_len;
        out_stall = 1'b0;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        forever
        begin
            stall_len = pick_gap();
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (pick_run()) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles < IDLE_LIMIT)
        begin
            idle_cycles <= idle_cycles + 1;
        end
        else
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int unsigned s;
        int unsigned fill;
        int unsigned r;
        bit          abandoned;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        kind        = KIND_CELL;
        cell_wall   = 1'b0;
        calm        = 1'b0;
        cells_sent  = 0;
        abandoned   = 1'b0;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drains with nothing pending, then a map left part done
        send_request(KIND_DRAIN, 1'b1);
        send_request(KIND_DRAIN, 1'b0);
        for (int i = 0; i < 12; i++)
            send_request(KIND_CELL, i[0] ^ i[1]);
        send_request(KIND_DRAIN, 1'b1);
        send_request(KIND_CELL, 1'b1);
        send_request(KIND_CELL, 1'b1);
        send_request(KIND_CELL, 1'b0);
        send_request(KIND_CELL, 1'b0);

        // side below range saturates, threshold zero makes every cell wall
        configure(1'b1, 8'd0, 1'b1, 4'd0);
        run_map(100, 11, 30, 1'b1);
        configure(1'b1, 8'd10, 1'b1, 4'd9);
        run_map(100, 11, 85, 1'b0);
        // threshold past nine, drain cut short, next map drops the old cells
        configure(1'b0, 8'd0, 1'b1, 4'd10);
        run_map(100, 3, 95, 1'b0);
        run_map(100, 11, 60, 1'b0);
        configure(1'b1, 8'd9, 1'b1, 4'd15);
        run_map(100, 14, 100, 1'b0);
        // widest map left part done twice, the second time with side above range
        configure(1'b1, 8'd128, 1'b1, 4'd4);
        run_map(300, 0, 50, 1'b0);
        configure(1'b1, 8'd255, 1'b1, 4'd5);
        run_map(2 * SIDE_LIMIT + 5, 0, 50, 1'b0);
        abandoned = 1'b1;

        while (cells_sent < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (abandoned || r < 50)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    s = $urandom_range(10, 16);
                else if (r < 95)
                    s = $urandom_range(17, 30);
                else
                    s = $urandom_range(0, 9);
                configure(1'b1, s[CFG_DATA_W-1:0], 1'($urandom_range(0, 1)),
                          THRESH_W'(($urandom_range(0, 99) < 70) ?
                                    $urandom_range(3, 7) : $urandom_range(0, 15)));
            end
            else if (r < 65)
            begin
                configure(1'b0, 8'd0, 1'b1,
                          THRESH_W'(($urandom_range(0, 99) < 70) ?
                                    $urandom_range(3, 7) : $urandom_range(0, 15)));
            end
            s = sb.side_now();
            fill = $urandom_range(0, 100);
            if ($urandom_range(0, 9) == 0)
            begin
                r = $urandom_range(1, s * s - 1);
                run_map(r, 0, fill, 1'b0);
                abandoned = 1'b1;
            end
            else
            begin
                r = pick_drains(s);
                run_map(s * s, r, fill, 1'b0);
                abandoned = 1'b0;
            end
        end

        calm = 1'b0;
        hold_for_results();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/core/bms_pkg.sv
rtl/core/bms_ram.sv
rtl/core/bms_front.sv
rtl/core/bms_window.sv
rtl/core/binary_majority_smoothing_3x3.sv
rtl/core/bms_checker.sv
test/binary_majority_smoothing_3x3_tb.sv
